@@ rtl/pstc_pkg.sv @@
// shared types, constants and the update sequence table of the stream statistics table
`default_nettype none

package pstc_pkg;

    // table geometry
    localparam int SLOTS        = 16;
    localparam int KEY_BITS     = 16;
    localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NUM_COUNTERS = 13;
    localparam int CNT_W        = 4;
    localparam int MEM_AW       = SLOT_W + CNT_W;
    localparam int MEM_DEPTH    = SLOTS * (2 ** CNT_W);

    typedef logic [KEY_BITS-1:0] key_t;
    typedef logic [SLOT_W-1:0]   slot_idx_t;
    typedef logic [MEM_AW-1:0]   mem_addr_t;

    // event kinds
    typedef enum logic [2:0] {
        FN_WRITE    = 3'd0,
        FN_DROP     = 3'd1,
        FN_UNDERRUN = 3'd2,
        FN_OVERRUN  = 3'd3,
        FN_RECOVERY = 3'd4,
        FN_FILL     = 3'd5,
        FN_RESET    = 3'd6,
        FN_SNAPSHOT = 3'd7
    } func_e;

    // result status codes
    typedef enum logic [1:0] {
        STS_DONE    = 2'd0,
        STS_IGNORED = 2'd1,
        STS_NO_SLOT = 2'd2
    } status_e;

    // counter order within a slot
    typedef enum logic [CNT_W-1:0] {
        CNT_CALLS     = 4'd0,
        CNT_REQUESTED = 4'd1,
        CNT_ACCEPTED  = 4'd2,
        CNT_DROPPED   = 4'd3,
        CNT_SHORT     = 4'd4,
        CNT_ZERO      = 4'd5,
        CNT_ERRORS    = 4'd6,
        CNT_UNDERRUN  = 4'd7,
        CNT_OVERRUN   = 4'd8,
        CNT_RECOVERY  = 4'd9,
        CNT_FILL_NOW  = 4'd10,
        CNT_FILL_PEAK = 4'd11,
        CNT_LAST_ERR  = 4'd12
    } cnt_e;

    // what the shared adder does in one step
    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_STORE = 2'd1,
        OP_MAX   = 2'd2,
        OP_CLAMP = 2'd3
    } op_mode_e;

    // second operand of a step
    typedef enum logic [2:0] {
        OPND_ONE     = 3'd0,
        OPND_FRAMES  = 3'd1,
        OPND_ACC     = 3'd2,
        OPND_ZERO    = 3'd3,
        OPND_SHORT   = 3'd4,
        OPND_OUTCOME = 3'd5
    } opnd_e;

    // one step of an update sequence
    typedef struct packed {
        logic     last;
        cnt_e     cidx;
        op_mode_e mode;
        opnd_e    opnd;
    } op_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_RD,
        S_EXE,
        S_SNAP_RD,
        S_SNAP_LD,
        S_OUT
    } state_e;

    // input item
    typedef struct packed {
        logic [2:0]         func;
        logic [15:0]        stream_id;
        logic signed [31:0] frame_count;
        logic signed [31:0] write_outcome;
    } evt_t;

    // result item
    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  counter_index;
        logic [63:0] counter_value;
        logic        last_of_run;
    } res_t;

    // update sequence: step number to counter, adder mode and operand
    function automatic op_t op_lookup(input func_e func, input logic err, input logic [3:0] step);
        op_t op;
        op = '{last: 1'b1, cidx: CNT_CALLS, mode: OP_ADD, opnd: OPND_ONE};
        unique case (func)
            FN_WRITE:
            begin
                if (err)
                begin
                    unique case (step)
                        4'd0:    op = '{1'b0, CNT_CALLS,     OP_ADD,   OPND_ONE};
                        4'd1:    op = '{1'b0, CNT_REQUESTED, OP_ADD,   OPND_FRAMES};
                        4'd2:    op = '{1'b0, CNT_ERRORS,    OP_ADD,   OPND_ONE};
                        default: op = '{1'b1, CNT_LAST_ERR,  OP_STORE, OPND_OUTCOME};
                    endcase
                end
                else
                begin
                    unique case (step)
                        4'd0:    op = '{1'b0, CNT_CALLS,     OP_CLAMP, OPND_ONE};
                        4'd1:    op = '{1'b0, CNT_CALLS,     OP_ADD,   OPND_ONE};
                        4'd2:    op = '{1'b0, CNT_REQUESTED, OP_ADD,   OPND_FRAMES};
                        4'd3:    op = '{1'b0, CNT_ACCEPTED,  OP_ADD,   OPND_ACC};
                        4'd4:    op = '{1'b0, CNT_ZERO,      OP_ADD,   OPND_ZERO};
                        default: op = '{1'b1, CNT_SHORT,     OP_ADD,   OPND_SHORT};
                    endcase
                end
            end
            FN_DROP:     op = '{1'b1, CNT_DROPPED,  OP_ADD, OPND_FRAMES};
            FN_UNDERRUN: op = '{1'b1, CNT_UNDERRUN, OP_ADD, OPND_ONE};
            FN_OVERRUN:  op = '{1'b1, CNT_OVERRUN,  OP_ADD, OPND_ONE};
            FN_RECOVERY: op = '{1'b1, CNT_RECOVERY, OP_ADD, OPND_ONE};
            FN_FILL:
            begin
                if (step == 4'd0)
                    op = '{1'b0, CNT_FILL_NOW,  OP_STORE, OPND_FRAMES};
                else
                    op = '{1'b1, CNT_FILL_PEAK, OP_MAX,   OPND_FRAMES};
            end
            default: op = '{1'b1, CNT_CALLS, OP_ADD, OPND_ONE};
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

@@ rtl/per_stream_stats_counter_table_unit.sv @@
// top level of the per-stream statistics counter table
`default_nettype none

// Per-stream statistics table: SLOTS slots keyed by stream id, thirteen counters
// each, held in a counter memory with one read and one write port, addressed by
// {slot, counter}. An item is taken only while the block is idle and every item
// gives its results before the next is taken. Key match and lowest-free-slot
// choice work over the key registers; each counter update then reads the memory
// and then makes one pass through the shared 64-bit adder with write back. A
// snapshot reads the counters one by one and gives one result per counter,
// reading the next counter only once the previous result is taken. Claiming a
// slot clears its counters at once through per-counter valid bits, so there is
// no clearing pass after reset.
module per_stream_stats_counter_table_unit
    import pstc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic evt_valid,
    output logic      evt_ready,
    input  wire evt_t evt,
    output logic      res_valid,
    input  wire logic res_ready,
    output res_t      res
);

    // sequencer and item registers
    state_e              state_reg, state_next;
    evt_t                evt_reg, evt_next;
    slot_idx_t           slot_reg, slot_next;
    logic [3:0]          step_reg, step_next;
    logic [31:0]         acc_reg, acc_next;
    logic                zero_reg, zero_next;
    logic                short_reg, short_next;
    res_t                res_reg, res_next;

    // slot directory
    logic [SLOTS-1:0]        slot_used_reg;
    key_t                    slot_key_reg [SLOTS];
    logic [NUM_COUNTERS-1:0] wvalid_reg [SLOTS];

    // counter memory
    logic [63:0] counter_mem [MEM_DEPTH];
    logic [63:0] rd_word_reg;
    logic        rd_valid_reg;

    // lookup
    key_t             key;
    logic [SLOTS-1:0] hit_vec;
    logic [SLOTS-1:0] free_vec;
    slot_idx_t        hit_idx;
    slot_idx_t        free_idx;

    // control towards the directory and memory
    logic        claim_en;
    logic        clr_en;
    slot_idx_t   clr_idx;
    logic        mem_we;
    logic [63:0] mem_wdata;
    logic [3:0]  rd_cidx;
    mem_addr_t   mem_raddr;
    mem_addr_t   mem_waddr;

    // shared adder
    op_t         op;
    logic [63:0] word;
    logic [63:0] operand;
    logic [63:0] add_a;
    logic [63:0] add_b;
    logic        add_cin;
    logic [63:0] add_sum;
    logic [63:0] frames_zx;
    logic [63:0] outcome_sx;
    logic [31:0] acc_val;

    assign evt_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT);
    assign res       = res_reg;

    // masked key of the held item
    always_comb
    begin
        for (int i = 0; i < KEY_BITS; i++)
        begin
            key[i] = (i < 16) ? evt_reg.stream_id[i % 16] : 1'b0;
        end
    end

    // key compare across the slots and slot choice
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            hit_vec[i]  = slot_used_reg[i] && (slot_key_reg[i] == key);
            free_vec[i] = !slot_used_reg[i];
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            if (hit_vec[i])
                hit_idx = hit_idx | SLOT_W'(i);
        end
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (free_vec[i])
                free_idx = SLOT_W'(i);
        end
    end

    // operands of the item
    assign frames_zx  = {32'd0, evt_reg.frame_count};
    assign outcome_sx = {{32{evt_reg.write_outcome[31]}}, evt_reg.write_outcome};
    assign op         = op_lookup(func_e'(evt_reg.func), evt_reg.write_outcome[31], step_reg);
    assign word       = rd_valid_reg ? rd_word_reg : 64'd0;

    // operand select
    always_comb
    begin
        unique case (op.opnd)
            OPND_ONE:     operand = 64'd1;
            OPND_FRAMES:  operand = frames_zx;
            OPND_ACC:     operand = {32'd0, acc_reg};
            OPND_ZERO:    operand = {63'd0, zero_reg};
            OPND_SHORT:   operand = {63'd0, short_reg};
            OPND_OUTCOME: operand = outcome_sx;
            default:      operand = 64'd0;
        endcase
    end

    // shared adder: add, or subtract for the compare steps
    always_comb
    begin
        unique case (op.mode)
            OP_MAX:
            begin
                add_a   = word;
                add_b   = ~frames_zx;
                add_cin = 1'b1;
            end
            OP_CLAMP:
            begin
                add_a   = frames_zx;
                add_b   = ~outcome_sx;
                add_cin = 1'b1;
            end
            default:
            begin
                add_a   = word;
                add_b   = operand;
                add_cin = 1'b0;
            end
        endcase
        add_sum = add_a + add_b + {63'd0, add_cin};
        acc_val = add_sum[63] ? evt_reg.frame_count : evt_reg.write_outcome;
    end

    // next state and control
    always_comb
    begin
        state_next = state_reg;
        evt_next   = evt_reg;
        slot_next  = slot_reg;
        step_next  = step_reg;
        acc_next   = acc_reg;
        zero_next  = zero_reg;
        short_next = short_reg;
        res_next   = res_reg;
        claim_en   = 1'b0;
        clr_en     = 1'b0;
        clr_idx    = slot_reg;
        mem_we     = 1'b0;
        mem_wdata  = add_sum;
        rd_cidx    = op.cidx;

        unique case (state_reg)
            S_IDLE:
            begin
                if (evt_valid)
                begin
                    evt_next   = evt;
                    state_next = S_FIND;
                end
            end

            S_FIND:
            begin
                step_next  = '0;
                state_next = S_OUT;
                res_next   = '{status: STS_DONE, counter_index: '0, counter_value: '0,
                               last_of_run: 1'b1};
                priority if (key == '0)
                begin
                    res_next.status = STS_IGNORED;
                end
                else if (evt_reg.func == FN_SNAPSHOT)
                begin
                    if (|hit_vec)
                    begin
                        slot_next  = hit_idx;
                        state_next = S_SNAP_RD;
                    end
                    else
                        res_next.status = STS_NO_SLOT;
                end
                else if (((evt_reg.func == FN_WRITE || evt_reg.func == FN_DROP) &&
                          (evt_reg.frame_count[31] || evt_reg.frame_count == 32'sd0)) ||
                         (evt_reg.func == FN_FILL && evt_reg.frame_count[31]))
                begin
                    res_next.status = STS_IGNORED;
                end
                else if ((|hit_vec) || (|free_vec))
                begin
                    // matched slot, or claim of the lowest free one
                    slot_next = (|hit_vec) ? hit_idx : free_idx;
                    clr_idx   = slot_next;
                    claim_en  = !(|hit_vec);
                    clr_en    = claim_en || (evt_reg.func == FN_RESET);
                    if (evt_reg.func != FN_RESET)
                        state_next = S_RD;
                end
                else
                begin
                    res_next.status = STS_NO_SLOT;
                end
            end

            S_RD:
            begin
                state_next = S_EXE;
            end

            S_EXE:
            begin
                unique case (op.mode)
                    OP_ADD:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = add_sum;
                    end
                    OP_STORE:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = operand;
                    end
                    OP_MAX:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = add_sum[63] ? frames_zx : word;
                    end
                    OP_CLAMP:
                    begin
                        acc_next   = acc_val;
                        zero_next  = (acc_val == 32'd0);
                        short_next = !add_sum[63] && (add_sum != 64'd0);
                    end
                    default:
                    begin
                        mem_we = 1'b0;
                    end
                endcase
                if (op.last)
                begin
                    res_next   = '{status: STS_DONE, counter_index: '0, counter_value: '0,
                                   last_of_run: 1'b1};
                    state_next = S_OUT;
                end
                else
                begin
                    step_next  = step_reg + 4'd1;
                    state_next = S_RD;
                end
            end

            S_SNAP_RD:
            begin
                rd_cidx    = step_reg;
                state_next = S_SNAP_LD;
            end

            S_SNAP_LD:
            begin
                res_next   = '{status: STS_DONE, counter_index: step_reg,
                               counter_value: word,
                               last_of_run: (step_reg == CNT_LAST_ERR)};
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (res_ready)
                begin
                    if (res_reg.last_of_run)
                        state_next = S_IDLE;
                    else
                    begin
                        step_next  = step_reg + 4'd1;
                        state_next = S_SNAP_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign mem_raddr = {slot_reg, rd_cidx};
    assign mem_waddr = {slot_reg, op.cidx};

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // slot use and counter valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_used_reg <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                wvalid_reg[i] <= '0;
            end
        end
        else
        begin
            if (claim_en)
                slot_used_reg[clr_idx] <= 1'b1;
            if (clr_en)
                wvalid_reg[clr_idx] <= '0;
            if (mem_we)
                wvalid_reg[slot_reg][op.cidx] <= 1'b1;
        end
    end

    // item payload and slot keys
    always_ff @(posedge clk)
    begin
        evt_reg   <= evt_next;
        slot_reg  <= slot_next;
        step_reg  <= step_next;
        acc_reg   <= acc_next;
        zero_reg  <= zero_next;
        short_reg <= short_next;
        res_reg   <= res_next;
        if (claim_en)
            slot_key_reg[clr_idx] <= key;
    end

    // counter memory, registered read
    always_ff @(posedge clk)
    begin
        rd_word_reg  <= counter_mem[mem_raddr];
        rd_valid_reg <= wvalid_reg[slot_reg][rd_cidx];
        if (mem_we)
            counter_mem[mem_waddr] <= mem_wdata;
    end

endmodule

`default_nettype wire

@@ rtl/pstc_checker.sv @@
// port checker for the statistics table and its bind
`default_nettype none

module pstc_checker
    import pstc_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic evt_valid,
    input wire logic evt_ready,
    input wire evt_t evt,
    input wire logic res_valid,
    input wire logic res_ready,
    input wire res_t res
);

    // one item at a time: never ready while a result is offered
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(evt_ready && res_valid))
        else $error("item taken while a result is pending");

    // an accepted item closes the input side at once
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_ready |=> !evt_ready)
        else $error("still ready after accepting an item");

    // a failed or ignored reply is a lone, empty result
    a_single_reply: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status != STS_DONE |->
            res.last_of_run && res.counter_index == 4'd0 && res.counter_value == 64'd0)
        else $error("bad single result");

    // a snapshot run keeps the input closed between its results
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res.last_of_run |=> !evt_ready)
        else $error("input opened in the middle of a snapshot run");

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed while stalled");

endmodule

bind per_stream_stats_counter_table_unit pstc_checker u_pstc_checker (.*);

`default_nettype wire
